FILE: rtl/p2bf_pkg.sv
// Shared types and constants of the power-of-two byte FIFO.
package p2bf_pkg;

	localparam int ADDR_BITS = 10;
	localparam int DEPTH     = 1 << ADDR_BITS;
	localparam int SIZE_W    = 4;
	localparam int CNT_W     = 10;
	localparam int BYTE_W    = 8;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);
	localparam logic [CNT_W-1:0]  BURST_MAX  = {CNT_W{1'b1}};

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;
	localparam logic [1:0] CMD_STATUS = 2'd3;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [BYTE_W-1:0] data_in;
		logic              burst_last;
	} req_beat_t;

	typedef struct packed {
		logic              accepted;
		logic              read_valid;
		logic [BYTE_W-1:0] read_byte;
		logic [CNT_W-1:0]  used_count;
		logic [CNT_W-1:0]  free_count;
		logic [CNT_W-1:0]  burst_written;
	} rsp_beat_t;

	typedef struct packed {
		logic accept;
		logic load;
	} ctl_cmd_t;

endpackage

FILE: rtl/p2bf_ram.sv
// Generic single-port RAM with registered read data.
module p2bf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: rtl/p2bf_ctrl.sv
// Controller state machine that sequences each beat through the FIFO.
module p2bf_ctrl import p2bf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ctl_cmd_t ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOAD = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_valid_q;

	assign cmd_stall  = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign ctl.accept = cmd_valid && !cmd_stall;
	assign ctl.load   = (state_q == ST_LOAD);
	assign rsp_valid  = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.accept) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A load always comes in the cycle after an accepted beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> $past(ctl.accept))
		else $error("load without a preceding accept");

	// The result register is loaded only when its previous beat is gone or leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |-> (!rsp_valid_q || !rsp_stall))
		else $error("accept while a stalled result is pending");

	// A new result appears only after a load.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(ctl.load))
		else $error("result valid without a load");

endmodule

FILE: rtl/p2bf_dp.sv
// Datapath: size register, ring pointers, burst counter, byte store and result register.
module p2bf_dp import p2bf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [SIZE_W-1:0] cfg_wr_data,
	input  req_beat_t         req,
	input  ctl_cmd_t          ctl,
	output rsp_beat_t         rsp
);

	logic [SIZE_W-1:0]    size_q;
	logic [SIZE_W-1:0]    size_eff;
	logic [ADDR_BITS-1:0] mask;
	logic [ADDR_BITS-1:0] wp_q;
	logic [ADDR_BITS-1:0] rp_q;
	logic [CNT_W-1:0]     bc_q;
	logic [ADDR_BITS-1:0] wp_d;
	logic [ADDR_BITS-1:0] rp_d;
	logic [CNT_W-1:0]     bc_d;
	logic [CNT_W-1:0]     bw;
	logic [ADDR_BITS-1:0] wp_next;
	logic [ADDR_BITS-1:0] used;
	logic                 acc;
	logic                 rv;
	logic                 ram_we;
	logic [ADDR_BITS-1:0] ram_addr;
	logic [BYTE_W-1:0]    ram_rdata;

	logic             acc_s1;
	logic             rv_s1;
	logic [CNT_W-1:0] used_s1;
	logic [CNT_W-1:0] free_s1;
	logic [CNT_W-1:0] bw_s1;
	rsp_beat_t        rsp_q;

	always_comb begin
		size_eff = size_q;
		if (size_q < SIZE_W'(1)) begin
			size_eff = SIZE_W'(1);
		end else if (size_q > SIZE_W'(ADDR_BITS)) begin
			size_eff = SIZE_W'(ADDR_BITS);
		end
	end

	assign mask    = ~({ADDR_BITS{1'b1}} << size_eff);
	assign wp_next = (wp_q + ADDR_BITS'(1)) & mask;

	always_comb begin
		wp_d     = wp_q;
		rp_d     = rp_q;
		bc_d     = bc_q;
		bw       = bc_q;
		acc      = 1'b0;
		rv       = 1'b0;
		ram_we   = 1'b0;
		ram_addr = rp_q;
		case (req.cmd)
			CMD_WRITE: begin
				ram_addr = wp_q;
				if (wp_next != rp_q) begin
					ram_we = ctl.accept;
					wp_d   = wp_next;
					acc    = 1'b1;
					if (bc_q < BURST_MAX) begin
						bw = bc_q + CNT_W'(1);
					end
				end
				bc_d = req.burst_last ? '0 : bw;
			end
			CMD_READ: begin
				if (wp_q != rp_q) begin
					rp_d = (rp_q + ADDR_BITS'(1)) & mask;
					rv   = 1'b1;
				end
			end
			CMD_FLUSH: begin
				wp_d = rp_q;
			end
			default: begin
			end
		endcase
	end

	assign used = (wp_d - rp_d) & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			wp_q   <= '0;
			rp_q   <= '0;
			bc_q   <= '0;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
			wp_q   <= '0;
			rp_q   <= '0;
			bc_q   <= '0;
		end else if (ctl.accept) begin
			wp_q <= wp_d;
			rp_q <= rp_d;
			bc_q <= bc_d;
		end
	end

	p2bf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (req.data_in),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			acc_s1  <= acc;
			rv_s1   <= rv;
			used_s1 <= CNT_W'(used);
			free_s1 <= CNT_W'(mask - used);
			bw_s1   <= bw;
		end
		if (ctl.load) begin
			rsp_q.accepted      <= acc_s1;
			rsp_q.read_valid    <= rv_s1;
			rsp_q.read_byte     <= rv_s1 ? ram_rdata : '0;
			rsp_q.used_count    <= used_s1;
			rsp_q.free_count    <= free_s1;
			rsp_q.burst_written <= bw_s1;
		end
	end

	assign rsp = rsp_q;

	// Pointers never leave the active ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		((wp_q & ~mask) == '0) && ((rp_q & ~mask) == '0))
		else $error("pointer outside the ring");

	// Used and free always add up to one less than the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> (rsp_q.used_count + rsp_q.free_count) == CNT_W'(mask))
		else $error("used and free counts disagree with the ring size");

	// A beat never both stores and returns a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |-> !(acc && rv))
		else $error("write and read reported on one beat");

endmodule

FILE: rtl/power_of_two_byte_fifo.sv
// Top level of the power-of-two byte FIFO.
// The byte store has a registered read, so the result of a command beat is loaded into
// the result register in the cycle after the beat is taken. A new beat is taken once the
// block is back in its idle state and the previous result has been taken or is being
// taken in that cycle. The ring holds 2^size_log2 bytes, size_log2 clamped to 1..10, with
// one slot kept empty; writing size_log2 empties the FIFO and takes effect at once.
module power_of_two_byte_fifo import p2bf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [SIZE_W-1:0] cfg_wr_data,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  req_beat_t         cmd_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_beat_t         rsp_data
);

	ctl_cmd_t ctl;

	p2bf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	p2bf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (cmd_data),
		.ctl         (ctl),
		.rsp         (rsp_data)
	);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the power-of-two byte FIFO: directed and random command beats.
module testbench;
	import p2bf_pkg::*;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [SIZE_W-1:0] cfg_wr_data = '0;
	logic              cmd_valid   = 1'b0;
	logic              cmd_stall;
	req_beat_t         cmd_data    = '0;
	logic              rsp_valid;
	logic              rsp_stall   = 1'b1;
	rsp_beat_t         rsp_data;

	power_of_two_byte_fifo uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data(cmd_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	logic [BYTE_W-1:0]    ring_mem [0:DEPTH-1];
	logic [ADDR_BITS-1:0] wr_ptr   = '0;
	logic [ADDR_BITS-1:0] rd_ptr   = '0;
	logic [CNT_W-1:0]     burst_cnt = '0;
	logic [SIZE_W-1:0]    size_reg = SIZE_RESET;

	rsp_beat_t rsp_expected [$];
	bit idle_on = 1'b1;
	int errors = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int bytes_stored = 0;
	int bytes_dropped = 0;
	int bytes_read = 0;
	int empty_reads = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic int ring_bits(input logic [SIZE_W-1:0] s);
		if (int'(s) < 1) return 1;
		if (int'(s) > ADDR_BITS) return ADDR_BITS;
		return int'(s);
	endfunction

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 17) : 0;
	endfunction

	function automatic rsp_beat_t ring_step(input req_beat_t b);
		rsp_beat_t r;
		logic [ADDR_BITS-1:0] m;
		logic [ADDR_BITS-1:0] nxt;
		logic [ADDR_BITS-1:0] used;
		r = '0;
		m = ADDR_BITS'((1 << ring_bits(size_reg)) - 1);
		wr_ptr = wr_ptr & m;
		rd_ptr = rd_ptr & m;
		case (b.cmd)
			CMD_WRITE: begin
				nxt = (wr_ptr + ADDR_BITS'(1)) & m;
				if (nxt != rd_ptr) begin
					ring_mem[wr_ptr] = b.data_in;
					wr_ptr = nxt;
					r.accepted = 1'b1;
					if (burst_cnt != BURST_MAX)
						burst_cnt = burst_cnt + CNT_W'(1);
					bytes_stored++;
				end else begin
					bytes_dropped++;
				end
				r.burst_written = burst_cnt;
				if (b.burst_last)
					burst_cnt = '0;
			end
			CMD_READ: begin
				if (wr_ptr != rd_ptr) begin
					r.read_valid = 1'b1;
					r.read_byte = ring_mem[rd_ptr];
					rd_ptr = (rd_ptr + ADDR_BITS'(1)) & m;
					bytes_read++;
				end else begin
					empty_reads++;
				end
			end
			CMD_FLUSH: wr_ptr = rd_ptr;
			default: ;
		endcase
		if (b.cmd != CMD_WRITE)
			r.burst_written = burst_cnt;
		used = (wr_ptr - rd_ptr) & m;
		r.used_count = used;
		r.free_count = m - used;
		return r;
	endfunction

	task automatic send_beat(input logic [1:0] cmd, input logic [BYTE_W-1:0] data,
			input logic last);
		int gap;
		req_beat_t b;
		b.cmd = cmd;
		b.data_in = data;
		b.burst_last = last;
		gap = draw_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= b;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		rsp_expected.push_back(ring_step(b));
		beats_sent++;
	endtask

	task automatic quiesce();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (rsp_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic config_write(input logic [SIZE_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		size_reg = value;
		wr_ptr = '0;
		rd_ptr = '0;
		burst_cnt = '0;
	endtask

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
			errors++;
		end
	endtask

	initial begin
		rsp_beat_t exp_rsp;
		rsp_beat_t got;
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (rsp_stall) begin
				rsp_stall <= 1'b0;
			end
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			got = rsp_data;
			if (rsp_expected.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, got);
				errors++;
			end else begin
				exp_rsp = rsp_expected.pop_front();
				check_field("accepted", int'(exp_rsp.accepted), int'(got.accepted));
				check_field("read_valid", int'(exp_rsp.read_valid), int'(got.read_valid));
				check_field("read_byte", int'(exp_rsp.read_byte), int'(got.read_byte));
				check_field("used_count", int'(exp_rsp.used_count), int'(got.used_count));
				check_field("free_count", int'(exp_rsp.free_count), int'(got.free_count));
				check_field("burst_written", int'(exp_rsp.burst_written),
					int'(got.burst_written));
				beats_checked++;
			end
		end
	end

	task automatic test_basic_commands();
		send_beat(CMD_STATUS, 8'h00, 1'b0);
		send_beat(CMD_READ, 8'hFF, 1'b1);
		send_beat(CMD_FLUSH, 8'h00, 1'b0);
		send_beat(CMD_WRITE, 8'h00, 1'b0);
		send_beat(CMD_WRITE, 8'hFF, 1'b0);
		send_beat(CMD_STATUS, 8'hFF, 1'b1);
		send_beat(CMD_WRITE, 8'h5A, 1'b1);
		send_beat(CMD_READ, 8'h00, 1'b0);
		send_beat(CMD_FLUSH, 8'hFF, 1'b1);
		send_beat(CMD_READ, 8'h00, 1'b0);
		send_beat(CMD_WRITE, 8'hA5, 1'b1);
		send_beat(CMD_READ, 8'h00, 1'b0);
		send_beat(CMD_STATUS, 8'h00, 1'b0);
	endtask

	task automatic test_small_rings();
		logic [SIZE_W-1:0] sizes [3] = '{4'd0, 4'd1, 4'd2};
		int cap;
		foreach (sizes[k]) begin
			quiesce();
			config_write(sizes[k]);
			cap = (1 << ring_bits(sizes[k])) - 1;
			for (int i = 0; i < cap + 2; i++)
				send_beat(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), i == cap + 1);
			for (int i = 0; i < cap + 1; i++)
				send_beat(CMD_READ, BYTE_W'($urandom_range(0, 255)), 1'b0);
			send_beat(CMD_STATUS, 8'h00, 1'b0);
		end
	endtask

	task automatic test_large_ring_full();
		quiesce();
		idle_on = 1'b0;
		config_write(4'd15);
		for (int i = 0; i < DEPTH; i++)
			send_beat(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0);
		for (int i = 0; i < 16; i++)
			send_beat(CMD_READ, 8'h00, 1'b0);
		idle_on = 1'b1;
	endtask

	task automatic test_burst_count_limit();
		idle_on = 1'b0;
		for (int i = 0; i < 16; i++)
			send_beat(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0);
		send_beat(CMD_WRITE, 8'hC3, 1'b1);
		send_beat(CMD_STATUS, 8'h00, 1'b0);
		send_beat(CMD_FLUSH, 8'h00, 1'b0);
		send_beat(CMD_READ, 8'h00, 1'b0);
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int target;
		int phase_end;
		int kind;
		int len;
		int cap;
		target = beats_sent + 800;
		while (beats_sent < target) begin
			quiesce();
			if ($urandom_range(0, 3) == 0)
				config_write(SIZE_W'($urandom_range(0, 15)));
			else
				config_write(SIZE_W'($urandom_range(1, 5)));
			idle_on = ($urandom_range(0, 3) != 0);
			cap = (1 << ring_bits(size_reg)) - 1;
			phase_end = beats_sent + $urandom_range(80, 250);
			while (beats_sent < phase_end && beats_sent < target) begin
				kind = $urandom_range(0, 9);
				if (kind < 5) begin
					len = $urandom_range(1, (cap + 2 > 40) ? 40 : cap + 2);
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 7) == 0)
							send_beat(2'($urandom_range(1, 3)),
								BYTE_W'($urandom_range(0, 255)),
								1'($urandom_range(0, 1)));
						send_beat(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), i == len - 1);
					end
				end else if (kind < 8) begin
					len = $urandom_range(1, (cap + 2 > 40) ? 40 : cap + 2);
					for (int i = 0; i < len; i++)
						send_beat(CMD_READ, BYTE_W'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
				end else if (kind == 8) begin
					send_beat(CMD_FLUSH, BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				end else begin
					send_beat(2'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				end
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_commands();
		test_small_rings();
		test_large_ring_full();
		test_burst_count_limit();
		test_random_traffic();
		quiesce();
		$display("Sent %0d beats and checked %0d results over ring sizes from 2 to 1024 bytes.",
			beats_sent, beats_checked);
		$display("Stored %0d bytes, dropped %0d on a full ring, read %0d, %0d reads found it empty.",
			bytes_stored, bytes_dropped, bytes_read, empty_reads);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: power_of_two_byte_fifo.f
rtl/p2bf_pkg.sv
rtl/p2bf_ram.sv
rtl/p2bf_ctrl.sv
rtl/p2bf_dp.sv
rtl/power_of_two_byte_fifo.sv
test/testbench.sv
